// ----- rtl/core/drtt_pkg.sv -----
`timescale 1ns / 1ps

package drtt_pkg;

  // Field widths fixed by the transaction format.
  localparam int unsigned FieldAddrW = 48;
  localparam int unsigned LenW       = 32;
  localparam int unsigned SlotIdxW   = 6;

  // Command codes carried by an input transaction.
  typedef enum logic [1:0] {
    CMD_RECORD  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_V2P     = 2'd2,
    CMD_P2V     = 2'd3
  } drtt_cmd_t;

  // Status codes carried by a result transaction.
  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_MISS = 2'd2
  } drtt_status_t;

  // Input transaction payload.
  typedef struct packed {
    drtt_cmd_t             command;
    logic [FieldAddrW-1:0] virt_addr;
    logic [FieldAddrW-1:0] phys_addr;
    logic [LenW-1:0]       length;
  } drtt_in_t;

  // Result transaction payload.
  typedef struct packed {
    drtt_status_t          status;
    logic [FieldAddrW-1:0] result_addr;
    logic [SlotIdxW-1:0]   slot_index;
  } drtt_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_FINISH
  } drtt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic alloc;
    logic scan;
    logic finish;
  } drtt_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rec_req;
    logic hit;
    logic miss;
  } drtt_stat_t;

endpackage

// ----- rtl/core/drtt_ctrl.sv -----
`timescale 1ns / 1ps

module drtt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  drtt_pkg::drtt_stat_t stat,
  output logic               busy,
  output drtt_pkg::drtt_ctrl_t ctrl
);

  drtt_pkg::drtt_state_t state_r;
  drtt_pkg::drtt_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= drtt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a record goes straight to allocation, everything else scans.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      drtt_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = stat.rec_req ? drtt_pkg::S_ALLOC : drtt_pkg::S_SCAN;
        end
      end
      drtt_pkg::S_ALLOC: begin
        state_nxt = drtt_pkg::S_IDLE;
      end
      drtt_pkg::S_SCAN: begin
        if (stat.hit || stat.miss) begin
          state_nxt = drtt_pkg::S_FINISH;
        end
      end
      drtt_pkg::S_FINISH: begin
        state_nxt = drtt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = drtt_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    busy        = 1'b1;
    ctrl.load   = 1'b0;
    ctrl.alloc  = 1'b0;
    ctrl.scan   = 1'b0;
    ctrl.finish = 1'b0;
    case (state_r)
      drtt_pkg::S_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      drtt_pkg::S_ALLOC: begin
        ctrl.alloc = 1'b1;
      end
      drtt_pkg::S_SCAN: begin
        ctrl.scan = 1'b1;
      end
      drtt_pkg::S_FINISH: begin
        ctrl.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/core/drtt_datapath.sv -----
`timescale 1ns / 1ps

module drtt_datapath #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  drtt_pkg::drtt_in_t   in_item,
  input  drtt_pkg::drtt_ctrl_t ctrl,
  output drtt_pkg::drtt_stat_t stat,
  output logic                 out_valid,
  output drtt_pkg::drtt_out_t  out_item
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned AW = (ADDR_BITS < drtt_pkg::FieldAddrW) ?
                               ADDR_BITS : drtt_pkg::FieldAddrW;
  localparam int unsigned CW = (AW > drtt_pkg::LenW) ? AW : drtt_pkg::LenW;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  // Region memories and valid bits.
  logic [AW-1:0]            mem_virt [SLOTS];
  logic [AW-1:0]            mem_phys [SLOTS];
  logic [drtt_pkg::LenW-1:0] mem_len [SLOTS];
  logic [SLOTS-1:0]         valid_r;

  // Latched transaction.
  drtt_pkg::drtt_cmd_t       cmd_r;
  logic [AW-1:0]             key_virt_r;
  logic [AW-1:0]             key_phys_r;
  logic [drtt_pkg::LenW-1:0] len_r;
  logic [IW-1:0]             free_idx_r;
  logic                      free_found_r;

  // Scan pipeline: read stage and compare stage.
  logic [IW-1:0]             rd_idx_r;
  logic                      issue_done_r;
  logic                      cmp_vld_r;
  logic                      cmp_ent_vld_r;
  logic                      cmp_last_r;
  logic [IW-1:0]             cmp_idx_r;
  logic [AW-1:0]             rd_virt_r;
  logic [AW-1:0]             rd_phys_r;
  logic [drtt_pkg::LenW-1:0] rd_len_r;

  // First hit captured for the finish step.
  logic                      hit_found_r;
  logic [IW-1:0]             hit_idx_r;
  logic [AW-1:0]             hit_diff_r;
  logic [AW-1:0]             hit_other_r;

  logic                      out_valid_r;
  drtt_pkg::drtt_out_t       out_item_r;

  logic [IW-1:0]             free_idx;
  logic                      issue;
  logic [AW-1:0]             key;
  logic [AW-1:0]             base;
  logic [AW-1:0]             other;
  logic [AW:0]               diff_ext;
  logic                      in_range;
  logic                      match;
  logic                      hit;
  logic [AW-1:0]             xlat_sum;

  // Lowest free slot, taken from the valid bits when a transaction is loaded.
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // Range test on the entry in the compare stage.
  always_comb begin
    key      = (cmd_r == drtt_pkg::CMD_V2P) ? key_virt_r : key_phys_r;
    base     = (cmd_r == drtt_pkg::CMD_V2P) ? rd_virt_r : rd_phys_r;
    other    = (cmd_r == drtt_pkg::CMD_V2P) ? rd_phys_r : rd_virt_r;
    diff_ext = {1'b0, key} - {1'b0, base};
    in_range = !diff_ext[AW] && (CW'(diff_ext[AW-1:0]) < CW'(rd_len_r));
    match    = (cmd_r == drtt_pkg::CMD_RELEASE) ? (rd_virt_r == key_virt_r) : in_range;
    hit      = cmp_vld_r && cmp_ent_vld_r && match;
  end

  assign issue    = ctrl.scan && !issue_done_r;
  assign xlat_sum = hit_other_r + hit_diff_r;

  assign stat.rec_req = (in_item.command == drtt_pkg::CMD_RECORD);
  assign stat.hit     = hit;
  assign stat.miss    = cmp_vld_r && cmp_last_r && !hit;

  // Memory write on record, registered read during the scan.
  always_ff @(posedge clk) begin
    if (ctrl.alloc && free_found_r) begin
      mem_virt[free_idx_r] <= key_virt_r;
      mem_phys[free_idx_r] <= key_phys_r;
      mem_len[free_idx_r]  <= len_r;
    end
    rd_virt_r <= mem_virt[rd_idx_r];
    rd_phys_r <= mem_phys[rd_idx_r];
    rd_len_r  <= mem_len[rd_idx_r];
  end

  // Transaction latch.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r        <= in_item.command;
      key_virt_r   <= AW'(in_item.virt_addr);
      key_phys_r   <= AW'(in_item.phys_addr);
      len_r        <= in_item.length;
      free_idx_r   <= free_idx;
      free_found_r <= ~&valid_r;
    end
  end

  // Scan control: one entry read per cycle, compared the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r     <= '0;
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
    end else if (ctrl.load) begin
      rd_idx_r     <= '0;
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (issue) begin
        issue_done_r <= (rd_idx_r == LastIdx);
        if (rd_idx_r != LastIdx) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end
      if (ctrl.scan && hit) begin
        hit_found_r <= 1'b1;
      end
    end
  end

  // Compare stage tags and the captured hit.
  always_ff @(posedge clk) begin
    cmp_ent_vld_r <= valid_r[rd_idx_r];
    cmp_last_r    <= (rd_idx_r == LastIdx);
    cmp_idx_r     <= rd_idx_r;
    if (ctrl.scan && hit) begin
      hit_idx_r   <= cmp_idx_r;
      hit_diff_r  <= diff_ext[AW-1:0];
      hit_other_r <= other;
    end
  end

  // Valid bits: set on record, cleared on a successful release.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctrl.alloc && free_found_r) begin
      valid_r[free_idx_r] <= 1'b1;
    end else if (ctrl.finish && hit_found_r && (cmd_r == drtt_pkg::CMD_RELEASE)) begin
      valid_r[hit_idx_r] <= 1'b0;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.alloc || ctrl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.alloc) begin
      out_item_r.result_addr <= '0;
      if (free_found_r) begin
        out_item_r.status     <= drtt_pkg::STS_OK;
        out_item_r.slot_index <= drtt_pkg::SlotIdxW'(free_idx_r);
      end else begin
        out_item_r.status     <= drtt_pkg::STS_FULL;
        out_item_r.slot_index <= '0;
      end
    end else if (ctrl.finish) begin
      if (hit_found_r) begin
        out_item_r.status     <= drtt_pkg::STS_OK;
        out_item_r.slot_index <= drtt_pkg::SlotIdxW'(hit_idx_r);
        if (cmd_r == drtt_pkg::CMD_RELEASE) begin
          out_item_r.result_addr <= '0;
        end else begin
          out_item_r.result_addr <= drtt_pkg::FieldAddrW'(xlat_sum);
        end
      end else begin
        out_item_r.status      <= drtt_pkg::STS_MISS;
        out_item_r.slot_index  <= '0;
        out_item_r.result_addr <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/core/dma_region_translation_table.sv -----
`timescale 1ns / 1ps

// Region translation table for DMA. A transaction is taken when start is high
// and busy is low; each transaction yields exactly one result, shown for one
// cycle with out_valid high, and the receiver cannot stall it, so it must take
// every strobe. A record command places the region in the lowest free slot
// found from the valid flops. Release and both lookups scan the region memory
// one slot per cycle, stopping at the first match; a miss scans every slot.
// The result strobe appears in the first idle cycle, so a new transaction can
// be started while it is shown. Reset clears all valid bits at once; no
// clearing pass is needed.
module dma_region_translation_table #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  drtt_pkg::drtt_in_t  in_item,
  output logic                out_valid,
  output drtt_pkg::drtt_out_t out_item
);

  drtt_pkg::drtt_ctrl_t ctrl;
  drtt_pkg::drtt_stat_t stat;

  // Sequencer.
  drtt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Table storage, scan and result logic.
  drtt_datapath #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/core/drtt_checker.sv -----
`timescale 1ns / 1ps

module drtt_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input drtt_pkg::drtt_in_t  in_item,
  input logic                out_valid,
  input drtt_pkg::drtt_out_t out_item
);

  // A result is only shown while the block is idle.
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Each transaction finishes with its result strobe.
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("transaction finished without a result");

  // The strobe lasts a single cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Failed transactions report zero address and slot.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != drtt_pkg::STS_OK)) |->
      ((out_item.result_addr == '0) && (out_item.slot_index == '0)))
    else $error("failed transaction with nonzero address or slot");

endmodule

bind dma_region_translation_table drtt_port_checker u_drtt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
